>>> hdl/sss_pkg.sv
// Shared types for the sequential sampling skip block.
package sss_pkg;

    // One input transfer: counts and the uniform variate.
    typedef struct packed {
        logic [31:0] records_remaining;
        logic [31:0] samples_remaining;
        logic [31:0] uniform_fraction;
    } t_in;

    // One output transfer: the skip and the bad-count flag.
    typedef struct packed {
        logic [31:0] skip_count;
        logic        invalid;
    } t_out;

    // Commands from the sequencer to the serial arithmetic unit.
    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_step;
    } t_unit_ctrl;

endpackage

>>> hdl/sequential_sampling_skip.sv
// Top level of the sequential sampling skip block (Vitter's method A).
//
// Usage: an input transfer carries N (records remaining), n (samples still
// wanted) and a uniform 0.FRACTION_BITS variate u. One output transfer
// follows for each input: the number of records to skip and an invalid flag
// that is set, with a zero skip, when n is 0, n exceeds N or N is 0.
// Both channels use valid/ready. The block takes one item at a time; while a
// result waits in the output register, the next item is already accepted.
// All arithmetic runs through one bit-serial unit that handles one bit per
// cycle. A bad-count item goes straight to the output; an item with n = 1
// takes one multiply, and other items take one divide and then a multiply
// and a divide for each record skipped.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
// A stalled receiver holds the result; the sequencer then waits with the next
// finished result until the output register frees.
module sequential_sampling_skip
    import sss_pkg::*;
#(
    parameter int COUNT_BITS    = 32,
    parameter int FRACTION_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int CW    = COUNT_BITS;
    localparam int FW    = FRACTION_BITS;
    localparam int CNT_W = $clog2(FW);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CW-1:0]    r_skip, n_skip;
    logic [CW-1:0]    r_mul_op, n_mul_op;
    logic [CW-1:0]    r_div_op, n_div_op;
    logic [FW-1:0]    r_u, n_u;
    logic             r_single, n_single;
    logic             r_inv, n_inv;
    logic             r_out_valid, n_out_valid;
    t_out             r_out, n_out;

    t_unit_ctrl       unit_ctrl;
    logic [CW+FW-1:0] unit_load;
    logic [CW-1:0]    unit_operand;
    logic [CW+FW-1:0] acc;

    logic [CW+31:0]   n_ext;
    logic [CW+31:0]   small_ext;
    logic [FW+31:0]   u_ext;
    logic [CW-1:0]    in_big;
    logic [CW-1:0]    in_small;
    logic [FW-1:0]    in_u;
    logic [CW-1:0]    in_top;
    logic             in_bad;
    logic             in_xfer;
    logic [FW-1:0]    q_cur;
    logic             keep_going;
    logic [CW-1:0]    result_skip;
    logic [CW+31:0]   skip_ext;
    logic             out_free;

    // Input fields narrowed or widened to the parameter widths.
    assign n_ext     = {{CW{1'b0}}, i_in_data.records_remaining};
    assign small_ext = {{CW{1'b0}}, i_in_data.samples_remaining};
    assign u_ext     = {{FW{1'b0}}, i_in_data.uniform_fraction};
    assign in_big    = n_ext[CW-1:0];
    assign in_small  = small_ext[CW-1:0];
    assign in_u      = u_ext[FW-1:0];
    assign in_top    = in_big - in_small;
    assign in_bad    = (in_big == '0) || (in_small == '0) || (in_small > in_big);

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;

    // Loop test: continue while the quotient exceeds u and the skip has room.
    assign q_cur      = acc[FW-1:0];
    assign keep_going = (q_cur > r_u) && (r_mul_op != '0);

    // The single-sample case takes its skip from the product's high part.
    assign result_skip = r_single ? acc[CW+FW-1:FW] : r_skip;
    assign skip_ext    = {32'd0, result_skip};
    assign out_free    = !r_out_valid || i_out_ready;

    // Operand and load selection for the serial unit.
    assign unit_operand = (r_state == ST_DIV) ? r_div_op : r_mul_op;

    always_comb begin
        unit_ctrl.load     = 1'b0;
        unit_ctrl.mul_step = (r_state == ST_MUL);
        unit_ctrl.div_step = (r_state == ST_DIV);
        unit_load          = {{CW{1'b0}}, q_cur};
        if (r_state == ST_IDLE) begin
            unit_ctrl.load = in_xfer && !in_bad;
            if (in_small == CW'(1)) begin
                unit_load = {{CW{1'b0}}, in_u};
            end else begin
                unit_load = {in_top, {FW{1'b0}}};
            end
        end else if (r_state == ST_CHECK) begin
            unit_ctrl.load = keep_going;
        end
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_skip      = r_skip;
        n_mul_op    = r_mul_op;
        n_div_op    = r_div_op;
        n_u         = r_u;
        n_single    = r_single;
        n_inv       = r_inv;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_skip   = '0;
                    n_u      = in_u;
                    n_cnt    = CNT_W'(FW - 1);
                    n_inv    = in_bad;
                    n_single = 1'b0;
                    if (in_bad) begin
                        n_state = ST_DONE;
                    end else if (in_small == CW'(1)) begin
                        n_single = 1'b1;
                        n_mul_op = in_big;
                        n_state  = ST_MUL;
                    end else begin
                        n_mul_op = in_top;
                        n_div_op = in_big;
                        n_state  = ST_DIV;
                    end
                end
            end
            ST_MUL: begin
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_cnt   = CNT_W'(FW - 1);
                    n_state = r_single ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_cnt   = CNT_W'(FW - 1);
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (keep_going) begin
                    n_skip   = r_skip + CW'(1);
                    n_mul_op = r_mul_op - CW'(1);
                    n_div_op = r_div_op - CW'(1);
                    n_state  = ST_MUL;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.skip_count = skip_ext[31:0];
                    n_out.invalid    = r_inv;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_skip   <= n_skip;
        r_mul_op <= n_mul_op;
        r_div_op <= n_div_op;
        r_u      <= n_u;
        r_single <= n_single;
        r_inv    <= n_inv;
        r_out    <= n_out;
    end

    sss_serial_unit #(
        .COUNT_BITS    (CW),
        .FRACTION_BITS (FW)
    ) u_serial_unit (
        .i_clk        (i_clk),
        .i_ctrl       (unit_ctrl),
        .i_load_value (unit_load),
        .i_operand    (unit_operand),
        .o_acc        (acc)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> hdl/sss_serial_unit.sv
// Bit-serial shift-add multiplier and restoring divider sharing one accumulator.
module sss_serial_unit
    import sss_pkg::*;
#(
    parameter int COUNT_BITS    = 32,
    parameter int FRACTION_BITS = 32
) (
    input  logic                                i_clk,
    input  t_unit_ctrl                          i_ctrl,
    input  logic [COUNT_BITS+FRACTION_BITS-1:0] i_load_value,
    input  logic [COUNT_BITS-1:0]               i_operand,
    output logic [COUNT_BITS+FRACTION_BITS-1:0] o_acc
);

    localparam int CW = COUNT_BITS;
    localparam int FW = FRACTION_BITS;

    logic [CW+FW-1:0] r_acc;
    logic [CW+FW-1:0] n_acc;
    logic [CW:0]      mul_sum;
    logic [CW:0]      div_rem;
    logic [CW+1:0]    div_diff;
    logic             div_ge;

    // Multiply step: add the operand into the high part when the low bit is set,
    // then shift the whole word right by one.
    assign mul_sum = {1'b0, r_acc[CW+FW-1:FW]} + (r_acc[0] ? {1'b0, i_operand} : '0);

    // Divide step: shift the next dividend bit into the remainder and subtract
    // the divisor when it fits; the quotient bit enters at the bottom.
    assign div_rem  = {r_acc[CW+FW-1:FW], r_acc[FW-1]};
    assign div_diff = {1'b0, div_rem} - {2'b00, i_operand};
    assign div_ge   = ~div_diff[CW+1];

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.load) begin
            n_acc = i_load_value;
        end else if (i_ctrl.mul_step) begin
            n_acc = {mul_sum, r_acc[FW-1:1]};
        end else if (i_ctrl.div_step) begin
            n_acc = {(div_ge ? div_diff[CW-1:0] : div_rem[CW-1:0]),
                     r_acc[FW-2:0], div_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule
